[rtl/core/mqmf_pkg.sv]
// ----------------------------------------------------------------------------
// mqmf_pkg
// Shared types and constants of the multi-queue message fifo.
// ----------------------------------------------------------------------------
`default_nettype none

package mqmf_pkg;

    localparam int unsigned QID_W    = 4;
    localparam int unsigned SENDER_W = 4;
    localparam int unsigned TTL_W    = 8;
    localparam int unsigned MSG_W    = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ENTRY_W  = SENDER_W + TTL_W + MSG_W;

    // operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_POP
    } t_state;

endpackage : mqmf_pkg

`default_nettype wire

[rtl/core/multi_queue_message_fifo.sv]
// ----------------------------------------------------------------------------
// multi_queue_message_fifo
// Per-peer message queues linked through one shared entry store.
// ----------------------------------------------------------------------------
// One word is worked on at a time. An enqueue or a rejected word (full store
// or empty queue) is decided once the queue pointer memory read is back; a
// dequeue of a non-empty queue then waits on the entry and link memory reads
// at the head. Free entries are handed out from a stack of returned entries
// first and then from a never-used counter, so no memory needs clearing after
// reset. A finished result sits in an output register while the next word is
// taken. Queue ids at or above NUM_QUEUES wrap modulo NUM_QUEUES.
`default_nettype none

module multi_queue_message_fifo #(
    parameter int unsigned NUM_QUEUES   = 16,
    parameter int unsigned BUFFER_DEPTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_operation,
    input  wire logic [mqmf_pkg::QID_W-1:0]        i_queue_id,
    input  wire logic [mqmf_pkg::SENDER_W-1:0]     i_sender,
    input  wire logic [mqmf_pkg::TTL_W-1:0]        i_ttl,
    input  wire logic [mqmf_pkg::MSG_W-1:0]        i_message,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [mqmf_pkg::STATUS_W-1:0]     o_status,
    output logic      [mqmf_pkg::SENDER_W-1:0]     o_out_sender,
    output logic      [mqmf_pkg::TTL_W-1:0]        o_out_ttl,
    output logic      [mqmf_pkg::MSG_W-1:0]        o_out_message
);

    import mqmf_pkg::*;

    localparam int unsigned QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned AW  = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned CW  = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned MW  = 9;  // wide enough for ids and NUM_QUEUES
    localparam int unsigned PTW = 2 * AW;
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [MW-1:0] NQ_C    = MW'(NUM_QUEUES);

    // control and item registers
    t_state r_state, n_state;
    logic                  r_op;
    logic [QW-1:0]         r_q;
    logic [SENDER_W-1:0]   r_sender;
    logic [TTL_W-1:0]      r_ttl;
    logic [MSG_W-1:0]      r_msg;
    logic [NUM_QUEUES-1:0] r_nonempty, n_nonempty;
    logic [CW-1:0]         r_stk_cnt, n_stk_cnt;
    logic [CW-1:0]         r_fresh, n_fresh;

    // result register
    logic                  r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [SENDER_W-1:0]   r_out_sender, n_out_sender;
    logic [TTL_W-1:0]      r_out_ttl, n_out_ttl;
    logic [MSG_W-1:0]      r_out_msg, n_out_msg;

    // memory ports
    logic           qp_wr_en, qp_rd_en;
    logic [QW-1:0]  qp_rd_addr;
    logic [PTW-1:0] qp_wr_data, qp_rd_data;
    logic           ent_wr_en, ent_rd_en;
    logic [AW-1:0]  ent_wr_addr, ent_rd_addr;
    logic [ENTRY_W-1:0] ent_wr_data, ent_rd_data;
    logic           lnk_wr_en;
    logic [AW-1:0]  lnk_wr_addr, lnk_wr_data, lnk_rd_data;
    logic           stk_wr_en, stk_rd_en;
    logic [AW-1:0]  stk_wr_addr, stk_rd_addr, stk_wr_data, stk_rd_data;

    logic          accept;
    logic          out_free;
    logic          full;
    logic [AW-1:0] alloc_idx;
    logic [AW-1:0] q_head, q_tail;
    logic [MW-1:0] qid_mod;
    logic [CW-1:0] stk_top;

    // queue id wrap by repeated subtraction, at most eight steps on 9 bits
    always_comb begin
        qid_mod = MW'(i_queue_id);
        for (int i = 0; i < 8; i++) begin
            if (qid_mod >= NQ_C) begin
                qid_mod = qid_mod - NQ_C;
            end
        end
    end

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || i_out_ready;
    assign stk_top     = r_stk_cnt - CW'(1);
    assign full        = (r_stk_cnt == '0) && (r_fresh == DEPTH_C);
    assign alloc_idx   = (r_stk_cnt != '0) ? stk_rd_data : r_fresh[AW-1:0];
    assign q_head      = qp_rd_data[PTW-1:AW];
    assign q_tail      = qp_rd_data[AW-1:0];
    assign qp_rd_en    = accept;
    assign qp_rd_addr  = qid_mod[QW-1:0];
    assign stk_rd_en   = accept;
    assign stk_rd_addr = stk_top[AW-1:0];
    assign ent_rd_addr = q_head;

    always_comb begin
        n_state      = r_state;
        n_nonempty   = r_nonempty;
        n_stk_cnt    = r_stk_cnt;
        n_fresh      = r_fresh;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_out_sender = r_out_sender;
        n_out_ttl    = r_out_ttl;
        n_out_msg    = r_out_msg;
        qp_wr_en     = 1'b0;
        qp_wr_data   = {q_head, alloc_idx};
        ent_wr_en    = 1'b0;
        ent_wr_addr  = alloc_idx;
        ent_wr_data  = {r_sender, r_ttl, r_msg};
        ent_rd_en    = 1'b0;
        lnk_wr_en    = 1'b0;
        lnk_wr_addr  = q_tail;
        lnk_wr_data  = alloc_idx;
        stk_wr_en    = 1'b0;
        stk_wr_addr  = r_stk_cnt[AW-1:0];
        stk_wr_data  = q_head;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (r_op == OP_DEQ && r_nonempty[r_q]) begin
                    // fetch head entry and its successor
                    ent_rd_en = 1'b1;
                    n_state   = S_POP;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sender = '0;
                    n_out_ttl    = '0;
                    n_out_msg    = '0;
                    n_state      = S_IDLE;
                    if (r_op == OP_DEQ) begin
                        n_status = ST_EMPTY;
                    end else if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status  = ST_OK;
                        ent_wr_en = 1'b1;
                        qp_wr_en  = 1'b1;
                        if (r_stk_cnt != '0) begin
                            n_stk_cnt = stk_top;
                        end else begin
                            n_fresh = r_fresh + CW'(1);
                        end
                        if (r_nonempty[r_q]) begin
                            lnk_wr_en  = 1'b1;
                            qp_wr_data = {q_head, alloc_idx};
                        end else begin
                            qp_wr_data      = {alloc_idx, alloc_idx};
                            n_nonempty[r_q] = 1'b1;
                        end
                    end
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_status     = ST_OK;
                    {n_out_sender, n_out_ttl, n_out_msg} = ent_rd_data;
                    n_state      = S_IDLE;
                    if (q_tail == q_head) begin
                        n_nonempty[r_q] = 1'b0;
                    end else begin
                        qp_wr_en   = 1'b1;
                        qp_wr_data = {lnk_rd_data, q_tail};
                    end
                    if (r_stk_cnt < DEPTH_C) begin
                        stk_wr_en = 1'b1;
                        n_stk_cnt = r_stk_cnt + CW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty  <= '0;
            r_stk_cnt   <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_nonempty  <= n_nonempty;
            r_stk_cnt   <= n_stk_cnt;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_operation;
            r_q      <= qid_mod[QW-1:0];
            r_sender <= i_sender;
            r_ttl    <= i_ttl;
            r_msg    <= i_message;
        end
        r_status     <= n_status;
        r_out_sender <= n_out_sender;
        r_out_ttl    <= n_out_ttl;
        r_out_msg    <= n_out_msg;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_out_sender  = r_out_sender;
    assign o_out_ttl     = r_out_ttl;
    assign o_out_message = r_out_msg;

    // head and tail pointers per queue
    mqmf_ram #(
        .WIDTH (PTW),
        .DEPTH (NUM_QUEUES)
    ) u_qptr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (qp_wr_en),
        .i_wr_addr (r_q),
        .i_wr_data (qp_wr_data),
        .i_rd_en   (qp_rd_en),
        .i_rd_addr (qp_rd_addr),
        .o_rd_data (qp_rd_data)
    );

    // sender, ttl and message per entry
    mqmf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (ent_wr_addr),
        .i_wr_data (ent_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (ent_rd_data)
    );

    // successor link per entry
    mqmf_ram #(
        .WIDTH (AW),
        .DEPTH (BUFFER_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lnk_wr_en),
        .i_wr_addr (lnk_wr_addr),
        .i_wr_data (lnk_wr_data),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (ent_rd_addr),
        .o_rd_data (lnk_rd_data)
    );

    // returned entries, last in first out
    mqmf_ram #(
        .WIDTH (AW),
        .DEPTH (BUFFER_DEPTH)
    ) u_free_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (stk_wr_addr),
        .i_wr_data (stk_wr_data),
        .i_rd_en   (stk_rd_en),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd_data)
    );

endmodule : multi_queue_message_fifo

`default_nettype wire

[rtl/core/mqmf_ram.sv]
// ----------------------------------------------------------------------------
// mqmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mqmf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule : mqmf_ram

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the multi-queue message fifo against a linked-store predictor.
// A short table of directed words covers empty queues, extreme field values
// and queue interleaving. Random bursts follow. Fill-heavy, drain-heavy and
// mixed traffic runs under several idle patterns on both channels, with
// long receiver hold-offs that back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mqmf_pkg::*;

    localparam int unsigned NUM_Q        = 16;
    localparam int unsigned DEPTH        = 64;
    localparam int unsigned RANDOM_WORDS = 600;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned FILL_WORDS   = 80;

    typedef struct packed {
        logic                op;
        logic [QID_W-1:0]    qid;
        logic [SENDER_W-1:0] sender;
        logic [TTL_W-1:0]    ttl;
        logic [MSG_W-1:0]    message;
    } t_msg_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SENDER_W-1:0] sender;
        logic [TTL_W-1:0]    ttl;
        logic [MSG_W-1:0]    message;
    } t_msg_resp;

    typedef struct packed {
        logic [SENDER_W-1:0] sender;
        logic [TTL_W-1:0]    ttl;
        logic [MSG_W-1:0]    message;
    } t_slot;

    // one directed word; known rows carry the response typed in by hand
    typedef struct packed {
        logic                op;
        logic [QID_W-1:0]    qid;
        logic [SENDER_W-1:0] sender;
        logic [TTL_W-1:0]    ttl;
        logic [MSG_W-1:0]    message;
        logic                known;
        logic [STATUS_W-1:0] st;
        logic [SENDER_W-1:0] r_sender;
        logic [TTL_W-1:0]    r_ttl;
        logic [MSG_W-1:0]    r_message;
    } t_dir_row;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_traffic;

    localparam int DIR_ROWS = 21;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{OP_DEQ, 4'd0,  4'd0,  8'h00, 32'h00000000, 1'b1, ST_EMPTY, 4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd15, 4'd0,  8'h00, 32'h00000000, 1'b1, ST_EMPTY, 4'd0,  8'h00, 32'h0},
        '{OP_ENQ, 4'd0,  4'd15, 8'hff, 32'hffffffff, 1'b1, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_ENQ, 4'd0,  4'd0,  8'h00, 32'h00000000, 1'b1, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_ENQ, 4'd15, 4'd5,  8'h0a, 32'h12345678, 1'b1, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd0,  4'd0,  8'h00, 32'h00000000, 1'b1, ST_OK,
          4'd15, 8'hff, 32'hffffffff},
        '{OP_ENQ, 4'd0,  4'd10, 8'h80, 32'ha5a5a5a5, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        // payload fields of a dequeue are ignored
        '{OP_DEQ, 4'd0,  4'd15, 8'hff, 32'hffffffff, 1'b1, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd0,  4'd0,  8'h00, 32'h00000000, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd0,  4'd0,  8'h00, 32'h00000000, 1'b1, ST_EMPTY, 4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd15, 4'd0,  8'h00, 32'h00000000, 1'b1, ST_OK,
          4'd5, 8'h0a, 32'h12345678},
        '{OP_ENQ, 4'd7,  4'd3,  8'h01, 32'h00000001, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_ENQ, 4'd8,  4'd12, 8'hfe, 32'h80000000, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_ENQ, 4'd7,  4'd9,  8'h80, 32'hfffffffe, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd8,  4'd0,  8'h00, 32'h00000000, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_ENQ, 4'd8,  4'd6,  8'h7f, 32'h5a5a5a5a, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd7,  4'd0,  8'h00, 32'h00000000, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd7,  4'd0,  8'h00, 32'h00000000, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd7,  4'd0,  8'h00, 32'h00000000, 1'b1, ST_EMPTY, 4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd8,  4'd0,  8'h00, 32'h00000000, 1'b0, ST_OK,    4'd0,  8'h00, 32'h0},
        '{OP_DEQ, 4'd8,  4'd0,  8'h00, 32'h00000000, 1'b1, ST_EMPTY, 4'd0,  8'h00, 32'h0}
    };

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                i_operation   = OP_ENQ;
    logic [QID_W-1:0]    i_queue_id    = '0;
    logic [SENDER_W-1:0] i_sender      = '0;
    logic [TTL_W-1:0]    i_ttl         = '0;
    logic [MSG_W-1:0]    i_message     = '0;
    logic                i_out_ready   = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [SENDER_W-1:0] o_out_sender;
    logic [TTL_W-1:0]    o_out_ttl;
    logic [MSG_W-1:0]    o_out_message;

    multi_queue_message_fifo #(
        .NUM_QUEUES   (NUM_Q),
        .BUFFER_DEPTH (DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_queue_id    (i_queue_id),
        .i_sender      (i_sender),
        .i_ttl         (i_ttl),
        .i_message     (i_message),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_sender  (o_out_sender),
        .o_out_ttl     (o_out_ttl),
        .o_out_message (o_out_message)
    );

    // predictor state: linked entry store shared by all queues
    logic [5:0] q_head  [NUM_Q];
    logic [5:0] q_tail  [NUM_Q];
    logic       q_live  [NUM_Q];
    t_slot      slots   [DEPTH];
    logic [5:0] links   [DEPTH];
    logic [5:0] free_list [DEPTH];
    logic [6:0] free_cnt;

    t_msg_resp   awaited_resps[$];
    int unsigned fail_count    = 0;
    int unsigned idle_phase    = 0;
    bit          hold_request  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(2_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic t_msg_resp predict_response(input t_msg_req r);
        t_msg_resp   res;
        logic [3:0]  q;
        logic [5:0]  idx;
        logic [5:0]  h;
        res = '0;
        q   = 4'(r.qid % NUM_Q);
        if (r.op == OP_ENQ) begin
            if (free_cnt == 7'd0) begin
                res.status = ST_FULL;
            end else begin
                free_cnt          = free_cnt - 7'd1;
                idx               = free_list[free_cnt[5:0]];
                slots[idx]        = '{r.sender, r.ttl, r.message};
                links[idx]        = '0;
                if (q_live[q]) begin
                    links[q_tail[q]] = idx;
                end else begin
                    q_head[q] = idx;
                    q_live[q] = 1'b1;
                end
                q_tail[q]  = idx;
                res.status = ST_OK;
            end
        end else begin
            if (!q_live[q]) begin
                res.status = ST_EMPTY;
            end else begin
                h           = q_head[q];
                res.status  = ST_OK;
                res.sender  = slots[h].sender;
                res.ttl     = slots[h].ttl;
                res.message = slots[h].message;
                if (q_tail[q] == h) begin
                    q_live[q] = 1'b0;
                    q_head[q] = '0;
                    q_tail[q] = '0;
                end else begin
                    q_head[q] = links[h];
                end
                if (free_cnt < 7'(DEPTH)) begin
                    free_list[free_cnt[5:0]] = h;
                    free_cnt                 = free_cnt + 7'd1;
                end
            end
        end
        return res;
    endfunction

    // offer one word, called right after a rising edge
    task automatic put_word(input t_msg_req r, input logic known, input t_msg_resp golden);
        int unsigned idle_pct;
        t_msg_resp   predicted;
        idle_pct = (idle_phase == 1) ? 86 : (idle_phase == 3) ? 31 : 0;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= r.op;
        i_queue_id  <= r.qid;
        i_sender    <= r.sender;
        i_ttl       <= r.ttl;
        i_message   <= r.message;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = predict_response(r);
        awaited_resps.push_back(known ? golden : predicted);
    endtask

    // result side: check accepted words, then choose ready for the next cycle
    initial begin : result_side
        int unsigned hold_left;
        int unsigned stall_pct;
        t_msg_resp   exp_resp;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (awaited_resps.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected word: status %0d sender %0d ttl %0d message %h",
                                 o_status, o_out_sender, o_out_ttl, o_out_message);
                    fail_count++;
                end else begin
                    exp_resp = awaited_resps.pop_front();
                    if (o_status !== exp_resp.status || o_out_sender !== exp_resp.sender ||
                        o_out_ttl !== exp_resp.ttl || o_out_message !== exp_resp.message) begin
                        if (fail_count < 10)
                            $display("mismatch: exp %0d/%0d/%0d/%h got %0d/%0d/%0d/%h",
                                     exp_resp.status, exp_resp.sender, exp_resp.ttl,
                                     exp_resp.message, o_status, o_out_sender, o_out_ttl,
                                     o_out_message);
                        fail_count++;
                    end
                end
            end
            if (hold_request && hold_left == 0) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            stall_pct = (idle_phase == 2) ? 86 : (idle_phase == 3) ? 31 : 0;
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin : stimulus
        t_msg_req    req;
        t_msg_resp   golden;
        t_traffic    mode;
        int unsigned enq_pct;
        int unsigned burst;
        int unsigned burst_len;
        int unsigned random_words;
        int unsigned start;
        logic [3:0]  cand;
        bit          found;

        for (int i = 0; i < NUM_Q; i++) begin
            q_head[i] = '0;
            q_tail[i] = '0;
            q_live[i] = 1'b0;
        end
        for (int i = 0; i < DEPTH; i++) begin
            slots[i]     = '0;
            links[i]     = '0;
            free_list[i] = i[5:0];
        end
        free_cnt = 7'(DEPTH);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            req    = '{DIRECTED[i].op, DIRECTED[i].qid, DIRECTED[i].sender,
                       DIRECTED[i].ttl, DIRECTED[i].message};
            golden = '{DIRECTED[i].st, DIRECTED[i].r_sender, DIRECTED[i].r_ttl,
                       DIRECTED[i].r_message};
            put_word(req, DIRECTED[i].known, golden);
        end

        random_words = 0;
        burst        = 0;
        while (random_words < RANDOM_WORDS) begin
            idle_phase = burst % 4;
            // the first burst fills the store past full
            mode = (burst == 0) ? MODE_FILL : t_traffic'($urandom_range(2));
            case (mode)
                MODE_FILL:  enq_pct = 90;
                MODE_DRAIN: enq_pct = 15;
                default:    enq_pct = 50;
            endcase
            if (burst == 0)
                enq_pct = 100;
            if (burst == 1 || $urandom_range(5) == 0)
                hold_request = 1'b1;
            burst_len = (burst == 0) ? FILL_WORDS : $urandom_range(100, 40);
            repeat (burst_len) begin
                req.op     = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DEQ;
                req.sender = 4'($urandom_range(15));
                case ($urandom_range(9))
                    0:       req.ttl = '0;
                    1:       req.ttl = '1;
                    default: req.ttl = 8'($urandom_range(255));
                endcase
                case ($urandom_range(9))
                    0:       req.message = '0;
                    1:       req.message = '1;
                    default: req.message = $urandom;
                endcase
                found = 1'b0;
                if (req.op == OP_DEQ && $urandom_range(99) < 70) begin
                    // aim most dequeues at a queue that holds something
                    start = $urandom_range(NUM_Q - 1);
                    for (int k = 0; k < NUM_Q; k++) begin
                        cand = 4'((start + k) % NUM_Q);
                        if (!found && q_live[cand]) begin
                            req.qid = cand;
                            found   = 1'b1;
                        end
                    end
                end
                if (!found)
                    req.qid = 4'($urandom_range(1) ? $urandom_range(3) : $urandom_range(15));
                put_word(req, 1'b0, '0);
                random_words++;
            end
            burst++;
        end

        i_in_valid <= 1'b0;
        while (awaited_resps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule : testbench

`default_nettype wire
